[src/art_pkg.sv]
// shared constants and types for the address resolution table
`default_nettype none
package art_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IP_W = 32;
	localparam int MAC_W = 48;
	localparam int SLOT_W = 4;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// request and its partial answer as it travels down the row of cells
	typedef struct packed {
		logic              opcode;
		logic [IP_W-1:0]   ip_address;
		logic [MAC_W-1:0]  mac_address;
		logic              found;
		logic [MAC_W-1:0]  mac_result;
		logic [SLOT_W-1:0] slot_index;
	} art_tok_t;

endpackage
`default_nettype wire

[src/address_resolution_table.sv]
// address resolution table top level: request register, row of slot cells, result register
//
// input channel: in_valid/in_ready with opcode, ip_address, mac_address per beat.
//   opcode lookup returns the mac of the lowest valid slot holding ip_address;
//   opcode update writes the lowest slot that is free or already holds the address.
// output channel: out_valid/out_ready with found, mac_result, slot_index, one beat per
//   input beat, in order. a miss or a dropped update (table full) gives all zeros.
// path: a request is held in the request register, then in each slot cell in turn from
//   slot 0 upward, then in the result register.
// occupancy: one request in the row at a time; the next request is taken only once
//   the previous one has walked through all the cells.
// in_ready rises as the previous request reaches the result register, and stays up
//   even while that result waits to be taken.
// stall: while a result waits and out_ready is low, the whole row holds until
//   out_ready takes the waiting beat; nothing is lost.
// reset: arst_n clears all valid marks and the handshake state at once; no clearing
//   pass is needed and in_ready is high as soon as reset is released.
`default_nettype none
module address_resolution_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        opcode,
	input  wire logic [art_pkg::IP_W-1:0]    ip_address,
	input  wire logic [art_pkg::MAC_W-1:0]   mac_address,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             found,
	output logic [art_pkg::MAC_W-1:0]        mac_result,
	output logic [art_pkg::SLOT_W-1:0]       slot_index
);
	import art_pkg::*;

	logic                   busy_q;
	logic                   req_vld_q;
	art_tok_t               req_q;
	logic                   out_valid_q;
	logic                   found_q;
	logic [MAC_W-1:0]       mac_result_q;
	logic [SLOT_W-1:0]      slot_index_q;
	logic                   advance;
	logic                   in_beat;
	logic                   done;
	logic [TABLE_ENTRIES:0] vld;
	art_tok_t               tok [TABLE_ENTRIES+1];

	assign in_beat  = in_valid && in_ready;
	assign in_ready = !busy_q;
	// hold the row whenever a result waits and out_ready is low
	assign advance  = !(out_valid_q && !out_ready);
	assign done     = vld[TABLE_ENTRIES] && advance;

	assign vld[0] = req_vld_q;
	assign tok[0] = req_q;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		art_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.slot_id   (SLOT_W'(k)),
			.tok_vld_i (vld[k]),
			.tok_i     (tok[k]),
			.tok_vld_o (vld[k+1]),
			.tok_o     (tok[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			req_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat) begin
				busy_q    <= 1'b1;
				req_vld_q <= 1'b1;
			end else begin
				if (advance) begin
					req_vld_q <= 1'b0;
				end
				if (done) begin
					busy_q <= 1'b0;
				end
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			req_q.opcode      <= opcode;
			req_q.ip_address  <= ip_address;
			req_q.mac_address <= mac_address;
			req_q.found       <= 1'b0;
			req_q.mac_result  <= '0;
			req_q.slot_index  <= '0;
		end
		if (done) begin
			found_q      <= tok[TABLE_ENTRIES].found;
			mac_result_q <= tok[TABLE_ENTRIES].mac_result;
			slot_index_q <= tok[TABLE_ENTRIES].slot_index;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign mac_result = mac_result_q;
	assign slot_index = slot_index_q;

	// one request in flight at most
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld) <= 1)
		else $error("more than one request in the row");

	// a request in the row is always accounted for by busy
	a_busy_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(|vld) |-> busy_q)
		else $error("request in the row while not busy");

	// misses and drops carry an all-zero answer
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (mac_result_q == '0 && slot_index_q == '0))
		else $error("nonzero payload on miss");

endmodule
`default_nettype wire

[src/art_cell.sv]
// one table slot: holds an entry and serves the request passing through it
`default_nettype none
module art_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic [art_pkg::SLOT_W-1:0] slot_id,
	input  wire logic                   tok_vld_i,
	input  wire art_pkg::art_tok_t      tok_i,
	output logic                        tok_vld_o,
	output art_pkg::art_tok_t           tok_o
);
	import art_pkg::*;

	logic             valid_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic             tok_vld_q;
	art_tok_t         tok_q;
	art_tok_t         nxt;
	logic             hit;
	logic             wr;

	always_comb begin
		nxt = tok_i;
		wr  = 1'b0;
		hit = valid_q && (ip_q == tok_i.ip_address);
		// an earlier slot already answered: pass through untouched
		if (tok_vld_i && !tok_i.found) begin
			if (tok_i.opcode == OP_LOOKUP) begin
				if (hit) begin
					nxt.found      = 1'b1;
					nxt.mac_result = mac_q;
					nxt.slot_index = slot_id;
				end
			end else if (!valid_q || hit) begin
				wr             = 1'b1;
				nxt.found      = 1'b1;
				nxt.slot_index = slot_id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else if (advance) begin
			tok_vld_q <= tok_vld_i;
			if (wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_q <= nxt;
			if (wr) begin
				ip_q  <= tok_i.ip_address;
				mac_q <= tok_i.mac_address;
			end
		end
	end

	assign tok_vld_o = tok_vld_q;
	assign tok_o     = tok_q;

	// entries are never removed
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |=> valid_q)
		else $error("slot valid mark dropped");

	// an update that reaches a free slot unanswered must claim it
	a_free_claimed: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && tok_vld_i && !tok_i.found && tok_i.opcode == OP_UPDATE && !valid_q)
		|=> (valid_q && tok_vld_q && tok_q.found && tok_q.slot_index == slot_id))
		else $error("update passed a free slot");

endmodule
`default_nettype wire
